>>> sv/hltd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the head/length/tail deframer.
// No dependencies.
package hltd_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int FILL_W     = 7;
	localparam int LEN_FLOOR  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd3;

	localparam logic [7:0]        HEAD_RST = 8'h5A;
	localparam logic [7:0]        TAIL_RST = 8'hA5;
	localparam logic [FILL_W-1:0] MIN_RST  = 7'd4;
	localparam logic [FILL_W-1:0] MAX_RST  = 7'd64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REPLAY_RD,
		ST_REPLAY_EV,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef struct packed {
		logic eval_in;
		logic eval_rd;
		logic rd_replay;
		logic rd_emit;
		logic emit_adv;
	} cmd_t;

	typedef struct packed {
		logic fail;
		logic done;
		logic replay_empty;
		logic emit_last;
	} stat_t;

endpackage

>>> sv/hltd_rx_if.sv
`timescale 1ns / 1ps
// Input channel: one received word per handshake.
// No dependencies.
interface hltd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic [7:0] conn_id;

	modport source (output valid, output rx_byte, output conn_id, input ready);
	modport sink (input valid, input rx_byte, input conn_id, output ready);
endinterface

>>> sv/hltd_frame_if.sv
`timescale 1ns / 1ps
// Output channel: one frame word per handshake.
// No dependencies.
interface hltd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;
	logic [6:0] frame_length;
	logic [7:0] out_conn_id;

	modport source (output valid, output frame_byte, output last, output frame_length,
		output out_conn_id, input ready);
	modport sink (input valid, input frame_byte, input last, input frame_length,
		input out_conn_id, output ready);
endinterface

>>> sv/hltd_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, circular frame store, frame tracking, emit pointer.
// Depends on hltd_pkg.
module hltd_datapath import hltd_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            conn_id,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic [7:0]            frame_byte,
	output logic                  last,
	output logic [FILL_W-1:0]     frame_length,
	output logic [7:0]            out_conn_id
);

	localparam int PTR_W = $clog2(STORE_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        rdata_q;
	logic [7:0]        head_q;
	logic [7:0]        tail_q;
	logic [FILL_W-1:0] min_q;
	logic [FILL_W-1:0] max_q;
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [PTR_W-1:0]  base_q;
	logic [PTR_W-1:0]  ep_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] flen_q;
	logic [FILL_W-1:0] ek_q;
	logic [7:0]        len_hi_q;
	logic [7:0]        conn_q;
	logic              collecting_q;

	logic [7:0]        byte_c;
	logic [PTR_W-1:0]  pos_c;
	logic [FILL_W-1:0] nfill_c;
	logic [15:0]       len_c;
	logic              ev_c;
	logic              head_hit_c;
	logic              len_bad_c;
	logic              check_len_c;
	logic              tail_chk_c;
	logic              fail_c;
	logic              done_c;
	logic              keep_c;

	always_comb begin
		ev_c        = cmd.eval_in | cmd.eval_rd;
		byte_c      = cmd.eval_rd ? rdata_q : rx_byte;
		pos_c       = cmd.eval_rd ? rd_q : wr_q;
		nfill_c     = fill_q + 1'b1;
		len_c       = {len_hi_q, byte_c};
		head_hit_c  = !collecting_q && (byte_c == head_q);
		keep_c      = head_hit_c || collecting_q;
		len_bad_c   = (len_c < 16'(LEN_FLOOR)) || (len_c < {9'b0, min_q}) ||
			(len_c > {9'b0, max_q}) || (len_c > 16'(STORE_DEPTH));
		check_len_c = collecting_q && (nfill_c == FILL_W'(3));
		tail_chk_c  = collecting_q && (nfill_c > FILL_W'(3)) && (nfill_c == flen_q);
		fail_c      = (check_len_c && len_bad_c) || (tail_chk_c && (byte_c != tail_q));
		done_c      = tail_chk_c && (byte_c == tail_q);
	end

	assign stat.fail         = fail_c;
	assign stat.done         = done_c;
	assign stat.replay_empty = (rd_q == wr_q);
	assign stat.emit_last    = (ek_q == flen_q - 1'b1);

	assign frame_byte   = rdata_q;
	assign last         = stat.emit_last;
	assign frame_length = flen_q;
	assign out_conn_id  = conn_q;

	always_ff @(posedge clk) begin
		if (cmd.eval_in) begin
			mem[wr_q] <= rx_byte;
		end
		if (cmd.rd_replay) begin
			rdata_q <= mem[rd_q];
		end else if (cmd.rd_emit) begin
			rdata_q <= mem[ep_q];
		end
		if (ev_c && collecting_q && (nfill_c == FILL_W'(2))) begin
			len_hi_q <= byte_c;
		end
		if (cmd.eval_in) begin
			conn_q <= conn_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= HEAD_RST;
			tail_q       <= TAIL_RST;
			min_q        <= MIN_RST;
			max_q        <= MAX_RST;
			wr_q         <= '0;
			rd_q         <= '0;
			base_q       <= '0;
			ep_q         <= '0;
			fill_q       <= '0;
			flen_q       <= '0;
			ek_q         <= '0;
			collecting_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_HEAD: head_q <= wr_data;
					REG_TAIL: tail_q <= wr_data;
					REG_MIN:  min_q  <= wr_data[FILL_W-1:0];
					REG_MAX:  max_q  <= wr_data[FILL_W-1:0];
					default:  ;
				endcase
			end
			if (ev_c) begin
				if (!collecting_q) begin
					if (head_hit_c) begin
						collecting_q <= 1'b1;
						fill_q       <= FILL_W'(1);
						base_q       <= pos_c;
					end
				end else begin
					fill_q <= nfill_c;
					if (check_len_c && !len_bad_c) begin
						flen_q <= len_c[FILL_W-1:0];
					end
					if (fail_c || done_c) begin
						collecting_q <= 1'b0;
					end
				end
				if (cmd.eval_in && keep_c) begin
					wr_q <= ptr_inc(wr_q);
				end
				// replay restarts just past the failed head
				if (fail_c) begin
					rd_q <= ptr_inc(base_q);
				end else if (cmd.eval_in) begin
					rd_q <= keep_c ? ptr_inc(wr_q) : wr_q;
				end else begin
					rd_q <= ptr_inc(rd_q);
				end
				if (done_c) begin
					ep_q <= base_q;
					ek_q <= '0;
				end
			end
			if (cmd.emit_adv) begin
				ep_q <= ptr_inc(ep_q);
				ek_q <= ek_q + 1'b1;
			end
		end
	end

endmodule

>>> sv/hltd_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences word intake, replay of stored words and frame emission.
// Depends on hltd_pkg.
module hltd_ctrl import hltd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.eval_in = 1'b1;
					if (stat.done) begin
						state_d = ST_EMIT_RD;
					end else if (stat.fail) begin
						state_d = ST_REPLAY_RD;
					end
				end
			end
			ST_REPLAY_RD: begin
				if (stat.replay_empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_replay = 1'b1;
					state_d       = ST_REPLAY_EV;
				end
			end
			ST_REPLAY_EV: begin
				cmd.eval_rd = 1'b1;
				state_d     = stat.done ? ST_EMIT_RD : ST_REPLAY_RD;
			end
			ST_EMIT_RD: begin
				cmd.rd_emit = 1'b1;
				state_d     = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.emit_adv = 1'b1;
					state_d      = stat.emit_last ? ST_REPLAY_RD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/head_length_tail_deframer_unit.sv
`timescale 1ns / 1ps
// Input words are taken at one word per cycle while no frame is emitted or replayed. A
// completed frame is emitted word by word: each word is read from the store (ST_EMIT_RD),
// then offered (ST_EMIT_OUT) until taken; ST_REPLAY_RD then precedes the next input word.
// After a failed frame, each stored word after the failed head is rescanned by a store read
// (ST_REPLAY_RD) and an evaluation (ST_REPLAY_EV), until ST_REPLAY_RD finds the store empty.
// Reset returns to hunting with default config; the store needs no clearing pass.
module head_length_tail_deframer_unit import hltd_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hltd_rx_if.sink               stream,
	hltd_frame_if.source          frame,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cmd_t  cmd;
	stat_t stat;

	hltd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stream.valid),
		.in_ready  (stream.ready),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	hltd_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.rx_byte      (stream.rx_byte),
		.conn_id      (stream.conn_id),
		.cmd          (cmd),
		.stat         (stat),
		.frame_byte   (frame.frame_byte),
		.last         (frame.last),
		.frame_length (frame.frame_length),
		.out_conn_id  (frame.out_conn_id)
	);

endmodule

>>> sv/hltd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the deframer, bound to the top level.
// Depends on hltd_pkg and head_length_tail_deframer_unit.
module hltd_checker import hltd_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        frame_byte,
	input logic              last,
	input logic [FILL_W-1:0] frame_length
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a frame word is offered");

	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("frame word offered right after an input word");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_length >= FILL_W'(LEN_FLOOR)) &&
			(frame_length <= FILL_W'(STORE_DEPTH)))
		else $error("frame length out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(frame_byte) && $stable(last))
		else $error("stalled frame word changed");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> !out_valid)
		else $error("no gap after end of frame");

endmodule

bind head_length_tail_deframer_unit hltd_checker #(
	.STORE_DEPTH (STORE_DEPTH)
) u_hltd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (stream.valid),
	.in_ready     (stream.ready),
	.out_valid    (frame.valid),
	.out_ready    (frame.ready),
	.frame_byte   (frame.frame_byte),
	.last         (frame.last),
	.frame_length (frame.frame_length)
);
